// ===== rtl/mgr_pkg.sv =====
// mgr_pkg: shared types, constants and helper functions for the masked grid
// reduction unit. No dependencies; imported by every rtl module of the block.
package mgr_pkg;

  localparam int NUM_VARS    = 8;
  localparam int VALUE_WIDTH = 32;
  localparam int ACC_VARS    = (NUM_VARS < 8) ? NUM_VARS : 8;
  localparam int ACC_IDX_W   = (ACC_VARS > 1) ? $clog2(ACC_VARS) : 1;
  localparam int ACC_W       = 64;
  localparam int CNT_W       = 32;
  localparam int MODE_W      = 4;
  localparam int VAL_SHIFT   = 32 - VALUE_WIDTH;

  // reduction mode codes
  localparam logic [MODE_W-1:0] MODE_MAX    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_MAXABS = 4'd1;
  localparam logic [MODE_W-1:0] MODE_MIN    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SUM    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_SUMSQ  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SUMABS = 4'd5;
  localparam logic [MODE_W-1:0] MODE_DOT    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_MSUMSQ = 4'd7;
  localparam logic [MODE_W-1:0] MODE_MSUM   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_DSUM   = 4'd9;

  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_SUM;

  // boundary classes
  localparam logic [1:0] BC_INTERIOR = 2'd0;
  localparam logic [1:0] BC_RELAXED  = 2'd1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_MAX,
    OP_MIN,
    OP_ADD
  } op_t;

  typedef struct packed {
    logic [2:0]         var_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] partner_value;
    logic               mask_a_set;
    logic               mask_b_set;
    logic [1:0]         boundary_class;
    logic               batch_last;
  } sample_t;

  typedef struct packed {
    logic [2:0]               out_var_index;
    logic signed [ACC_W-1:0]  accumulate_out;
    logic [CNT_W-1:0]         point_count;
    logic                     saturated;
    logic                     result_last;
  } result_t;

  // prepared operand travelling from the term stage to the accumulator stage
  typedef struct packed {
    logic                    valid;
    logic [ACC_IDX_W-1:0]    idx;
    op_t                     op;
    logic                    update;
    logic                    count;
    logic                    last;
    logic signed [ACC_W-1:0] term;
  } term_t;

  typedef logic [ACC_VARS-1:0][ACC_W-1:0] acc_bank_t;
  typedef logic [ACC_VARS-1:0]            clip_bank_t;

  // unused codes fall back to plain sum
  function automatic logic [MODE_W-1:0] eff_mode(input logic [MODE_W-1:0] mode);
    return (mode <= MODE_DSUM) ? mode : MODE_SUM;
  endfunction

  function automatic logic signed [ACC_W-1:0] init_value(input logic [MODE_W-1:0] m);
    logic signed [ACC_W-1:0] v;
    v = '0;
    if (m == MODE_MAX || m == MODE_MAXABS) v = ACC_MIN;
    else if (m == MODE_MIN) v = ACC_MAX;
    return v;
  endfunction

  // keep the low VALUE_WIDTH bits and sign-extend them back to 32
  function automatic logic signed [31:0] sext_value(input logic [31:0] raw);
    logic signed [31:0] t;
    t = raw << VAL_SHIFT;
    return t >>> VAL_SHIFT;
  endfunction

endpackage

// ===== rtl/mgr_term.sv =====
// mgr_term: input register and operand stage (sign extension, abs, Q16.16
// product, mode decode). Depends on mgr_pkg.
module mgr_term (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  mgr_pkg::sample_t sample,
  input  logic             hold,
  input  logic [3:0]       mode,
  output mgr_pkg::term_t   term
);
  import mgr_pkg::*;

  logic               a_valid;
  sample_t            a_item;
  term_t              term_next;

  logic [MODE_W-1:0]  m;
  logic signed [31:0] u;
  logic signed [31:0] w;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] qprod;
  logic signed [63:0] u64;
  logic signed [63:0] au64;
  logic               bc_ok;
  logic               in_range;

  // operand preparation
  always_comb begin
    m        = eff_mode(mode);
    u        = sext_value(a_item.sample_value);
    w        = sext_value(a_item.partner_value);
    u64      = {{32{u[31]}}, u};
    au64     = u[31] ? -u64 : u64;
    mul_b    = (m == MODE_DOT) ? w : u;
    prod     = u * mul_b;
    qprod    = prod >>> 16;
    bc_ok    = (m == MODE_DSUM) ? (a_item.boundary_class == BC_INTERIOR ||
                                   a_item.boundary_class == BC_RELAXED)
                                : (a_item.boundary_class == BC_INTERIOR);
    in_range = int'(a_item.var_index) < NUM_VARS;

    term_next        = '0;
    term_next.valid  = a_valid;
    term_next.idx    = a_item.var_index[ACC_IDX_W-1:0];
    term_next.last   = a_item.batch_last;
    term_next.count  = bc_ok && in_range && (m >= MODE_SUM);
    term_next.update = bc_ok && in_range;
    term_next.op     = OP_ADD;
    term_next.term   = u64;

    unique case (m)
      MODE_MAX: begin
        term_next.op = OP_MAX;
      end
      MODE_MAXABS: begin
        term_next.op   = OP_MAX;
        term_next.term = au64;
      end
      MODE_MIN: begin
        term_next.op = OP_MIN;
      end
      MODE_SUMSQ, MODE_DOT: begin
        term_next.term = qprod;
      end
      MODE_SUMABS: begin
        term_next.term = au64;
      end
      MODE_MSUMSQ: begin
        term_next.term   = qprod;
        term_next.update = bc_ok && in_range && !a_item.mask_a_set;
      end
      MODE_MSUM: begin
        term_next.update = bc_ok && in_range && !a_item.mask_a_set;
      end
      MODE_DSUM: begin
        term_next.update = bc_ok && in_range && !a_item.mask_a_set && !a_item.mask_b_set;
      end
      default: begin
      end
    endcase
  end

  // both stages shift together unless the accumulator stage holds
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      term.valid <= 1'b0;
    end else if (!hold) begin
      a_valid <= sample_valid;
      a_item  <= sample;
      term    <= term_next;
    end
  end

endmodule

// ===== rtl/mgr_accum.sv =====
// mgr_accum: mode register, per-variable accumulator bank, clip flags and the
// shared point counter; hands a snapshot to the drain on batch end. Uses mgr_pkg.
module mgr_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  mgr_pkg::term_t      term,
  input  logic                drain_busy,
  output logic                hold,
  output logic [3:0]          mode,
  output logic                load,
  output mgr_pkg::acc_bank_t  snap_acc,
  output mgr_pkg::clip_bank_t snap_clip,
  output logic [31:0]         snap_count
);
  import mgr_pkg::*;

  acc_bank_t               acc;
  clip_bank_t              clip;
  logic [CNT_W-1:0]        count;

  logic [MODE_W-1:0]       m;
  logic                    adv;
  logic signed [ACC_W-1:0] cur;
  logic signed [ACC_W-1:0] new_val;
  logic                    new_clip;
  logic [ACC_W:0]          sum;
  logic [CNT_W-1:0]        count_upd;
  acc_bank_t               acc_upd;
  clip_bank_t              clip_upd;

  // a batch end waits while the previous results are still going out
  assign hold = term.valid && term.last && drain_busy;
  assign adv  = term.valid && !hold;
  assign m    = eff_mode(mode);
  assign load = adv && term.last;

  // read-modify-write of the selected accumulator
  always_comb begin
    cur      = $signed(acc[term.idx]);
    new_val  = cur;
    new_clip = clip[term.idx];
    sum      = {cur[ACC_W-1], cur} + {term.term[ACC_W-1], term.term};
    unique case (term.op)
      OP_MAX: begin
        if (term.term > cur) new_val = term.term;
      end
      OP_MIN: begin
        if (term.term < cur) new_val = term.term;
      end
      default: begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
          new_val  = sum[ACC_W] ? ACC_MIN : ACC_MAX;
          new_clip = 1'b1;
        end else begin
          new_val = $signed(sum[ACC_W-1:0]);
        end
      end
    endcase

    acc_upd  = acc;
    clip_upd = clip;
    if (term.update) begin
      acc_upd[term.idx]  = new_val;
      clip_upd[term.idx] = new_clip;
    end

    count_upd = count;
    if (term.count && count != {CNT_W{1'b1}}) count_upd = count + CNT_W'(1);
  end

  assign snap_acc   = acc_upd;
  assign snap_clip  = clip_upd;
  assign snap_count = (m >= MODE_SUM) ? count_upd : '0;

  // bank state, reinitialized on reset, mode write and batch end
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_RESET;
      acc   <= {ACC_VARS{init_value(MODE_RESET)}};
      clip  <= '0;
      count <= '0;
    end else if (cfg_we) begin
      mode  <= cfg_wdata;
      acc   <= {ACC_VARS{init_value(eff_mode(cfg_wdata))}};
      clip  <= '0;
      count <= '0;
    end else if (adv) begin
      if (term.last) begin
        acc   <= {ACC_VARS{init_value(m)}};
        clip  <= '0;
        count <= '0;
      end else begin
        acc   <= acc_upd;
        clip  <= clip_upd;
        count <= count_upd;
      end
    end
  end

endmodule

// ===== rtl/mgr_drain.sv =====
// mgr_drain: result snapshot bank and output sequencer, one result per
// variable in index order. Uses mgr_pkg.
module mgr_drain (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  mgr_pkg::acc_bank_t  snap_acc,
  input  mgr_pkg::clip_bank_t snap_clip,
  input  logic [31:0]         snap_count,
  output logic                busy,
  output logic                result_valid,
  input  logic                result_stall,
  output mgr_pkg::result_t    result
);
  import mgr_pkg::*;

  localparam logic [ACC_IDX_W-1:0] LAST_IDX = ACC_IDX_W'(ACC_VARS - 1);

  acc_bank_t            sh_acc;
  clip_bank_t           sh_clip;
  logic [CNT_W-1:0]     sh_count;
  logic [ACC_IDX_W-1:0] cnt;
  logic                 out_done;

  // result payload comes straight from the snapshot registers
  assign result_valid          = busy;
  assign result.out_var_index  = 3'(cnt);
  assign result.accumulate_out = $signed(sh_acc[cnt]);
  assign result.point_count    = sh_count;
  assign result.saturated      = sh_clip[cnt];
  assign result.result_last    = (cnt == LAST_IDX);
  assign out_done              = busy && !result_stall;

  // snapshot capture and index stepping
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy     <= 1'b1;
      cnt      <= '0;
      sh_acc   <= snap_acc;
      sh_clip  <= snap_clip;
      sh_count <= snap_count;
    end else if (out_done) begin
      if (cnt == LAST_IDX) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + ACC_IDX_W'(1);
      end
    end
  end

  // a new snapshot never lands on results still going out
  a_load_idle: assert property (@(posedge clk) disable iff (rst) load |-> !busy)
    else $error("snapshot loaded while results pending");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> (result_valid && cnt == '0))
    else $error("drain did not start at variable zero");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && result.result_last && !load) |=> !result_valid)
    else $error("results continue after the last one of the batch");

endmodule

// ===== rtl/masked_grid_reduction_unit.sv =====
// masked_grid_reduction_unit: top level of the masked grid reduction block.
// Depends on mgr_pkg, mgr_term, mgr_accum and mgr_drain.
//
//   channel   direction  handshake                     payload
//   sample    in         sample_valid / sample_stall   mgr_pkg::sample_t
//   result    out        result_valid / result_stall   mgr_pkg::result_t
//   config    in         cfg_we (write only)           cfg_wdata[3:0] = reduce_mode
//
// One sample per cycle is accepted while sample_stall is low; the accumulator
// update is a saturating add/compare on the selected bank entry, fed through
// the input and term registers. A batch end copies the bank into a snapshot
// that drains one result a cycle while result_stall is low. A second batch end
// reaching the accumulator while a snapshot still drains stalls the sample input
// until it is free. Synchronous reset restores mode sum and reset accumulators.
module masked_grid_reduction_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  mgr_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output mgr_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_wdata
);
  import mgr_pkg::*;

  term_t      term;
  logic       hold;
  logic [3:0] mode;
  logic       load;
  logic       drain_busy;
  acc_bank_t  snap_acc;
  clip_bank_t snap_clip;
  logic [31:0] snap_count;

  assign sample_stall = hold;

  // operand stage
  mgr_term u_term (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample       (sample),
    .hold         (hold),
    .mode         (mode),
    .term         (term)
  );

  // accumulator bank
  mgr_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .term       (term),
    .drain_busy (drain_busy),
    .hold       (hold),
    .mode       (mode),
    .load       (load),
    .snap_acc   (snap_acc),
    .snap_clip  (snap_clip),
    .snap_count (snap_count)
  );

  // result sequencer
  mgr_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .snap_acc     (snap_acc),
    .snap_clip    (snap_clip),
    .snap_count   (snap_count),
    .busy         (drain_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
